### sv/fmbq_pkg.sv
`timescale 1ns / 1ps

package fmbq_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int OUT_CNT_W = 11;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_MIDDLE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_MIDDLE  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK    = 3'd5;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic pop_rd;
    logic pop_from_b;
    logic move;
    logic move_from_b;
    logic move_from_in;
    logic push_wr;
    logic push_to_b;
    logic was_empty;
    logic push_dropped;
  } fmbq_plan_t;

endpackage

### sv/fmbq_mem.sv
`timescale 1ns / 1ps

module fmbq_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fmbq_pkg::DATA_W-1:0] wr_data,
  output logic [fmbq_pkg::DATA_W-1:0] rd_data
);
  import fmbq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/fmbq_plan.sv
`timescale 1ns / 1ps

module fmbq_plan #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int CW       = 11
) (
  input  logic [fmbq_pkg::ACTION_W-1:0] action,
  input  logic [CW-1:0]                 f_cnt,
  input  logic [AW-1:0]                 f_head,
  input  logic [CW-1:0]                 b_cnt,
  input  logic [AW-1:0]                 b_head,
  output fmbq_pkg::fmbq_plan_t          plan,
  output logic [AW-1:0]                 pop_addr,
  output logic [AW-1:0]                 mv_rd_addr,
  output logic [AW-1:0]                 mv_wr_addr,
  output logic [AW-1:0]                 push_addr,
  output logic [CW-1:0]                 new_f_cnt,
  output logic [AW-1:0]                 new_f_head,
  output logic [CW-1:0]                 new_b_cnt,
  output logic [AW-1:0]                 new_b_head
);
  import fmbq_pkg::*;

  localparam logic [AW:0]   CAP_W = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL  = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE   = CW'(1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] k);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  logic [CW-1:0] total;
  logic [CW-1:0] f_m1;
  logic [CW-1:0] b_m1;
  logic          full;
  logic          empty;
  logic          f_eq_b;
  logic          f_eq_b1;
  logic [AW-1:0] a_flast;
  logic [AW-1:0] a_fend;
  logic [AW-1:0] a_blast;
  logic [AW-1:0] a_bend;
  logic [AW-1:0] fh_dec;
  logic [AW-1:0] fh_inc;
  logic [AW-1:0] bh_dec;
  logic [AW-1:0] bh_inc;

  assign total   = f_cnt + b_cnt;
  assign f_m1    = f_cnt - ONE;
  assign b_m1    = b_cnt - ONE;
  assign full    = (total == FULL);
  assign empty   = (total == '0);
  assign f_eq_b  = (f_cnt == b_cnt);
  assign f_eq_b1 = (f_cnt == b_cnt + ONE);
  assign a_flast = wrap_add(f_head, f_m1[AW-1:0]);
  assign a_fend  = wrap_add(f_head, f_cnt[AW-1:0]);
  assign a_blast = wrap_add(b_head, b_m1[AW-1:0]);
  assign a_bend  = wrap_add(b_head, b_cnt[AW-1:0]);
  assign fh_dec  = (f_head == '0) ? LAST : f_head - AW'(1);
  assign bh_dec  = (b_head == '0) ? LAST : b_head - AW'(1);
  assign fh_inc  = wrap_add(f_head, AW'(1));
  assign bh_inc  = wrap_add(b_head, AW'(1));

  always_comb begin
    plan       = '0;
    pop_addr   = '0;
    mv_rd_addr = '0;
    mv_wr_addr = '0;
    push_addr  = '0;
    new_f_cnt  = f_cnt;
    new_f_head = f_head;
    new_b_cnt  = b_cnt;
    new_b_head = b_head;
    case (action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          plan.push_dropped = 1'b1;
        end else begin
          plan.push_wr = 1'b1;
          push_addr    = fh_dec;
          new_f_head   = fh_dec;
          if (f_eq_b1) begin
            plan.move  = 1'b1;
            mv_rd_addr = a_flast;
            mv_wr_addr = bh_dec;
            new_b_head = bh_dec;
            new_b_cnt  = b_cnt + ONE;
          end else begin
            new_f_cnt = f_cnt + ONE;
          end
        end
      end
      ACT_PUSH_MIDDLE: begin
        if (full) begin
          plan.push_dropped = 1'b1;
        end else begin
          plan.push_wr = 1'b1;
          if (f_eq_b1) begin
            plan.move  = 1'b1;
            mv_rd_addr = a_flast;
            mv_wr_addr = bh_dec;
            new_b_head = bh_dec;
            new_b_cnt  = b_cnt + ONE;
            push_addr  = a_flast;
          end else begin
            push_addr = a_fend;
            new_f_cnt = f_cnt + ONE;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          plan.push_dropped = 1'b1;
        end else begin
          plan.push_wr   = 1'b1;
          plan.push_to_b = 1'b1;
          push_addr      = a_bend;
          if (f_eq_b) begin
            plan.move         = 1'b1;
            plan.move_from_b  = 1'b1;
            plan.move_from_in = (b_cnt == '0);
            mv_rd_addr        = b_head;
            mv_wr_addr        = a_fend;
            new_b_head        = bh_inc;
            new_f_cnt         = f_cnt + ONE;
          end else begin
            new_b_cnt = b_cnt + ONE;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          plan.was_empty = 1'b1;
        end else begin
          plan.pop_rd = 1'b1;
          pop_addr    = f_head;
          new_f_head  = fh_inc;
          if (f_eq_b) begin
            plan.move        = 1'b1;
            plan.move_from_b = 1'b1;
            mv_rd_addr       = b_head;
            mv_wr_addr       = a_fend;
            new_b_head       = bh_inc;
            new_b_cnt        = b_m1;
          end else begin
            new_f_cnt = f_m1;
          end
        end
      end
      ACT_POP_MIDDLE: begin
        if (empty) begin
          plan.was_empty = 1'b1;
        end else begin
          plan.pop_rd = 1'b1;
          pop_addr    = a_flast;
          if (f_eq_b) begin
            plan.move        = 1'b1;
            plan.move_from_b = 1'b1;
            mv_rd_addr       = b_head;
            mv_wr_addr       = a_flast;
            new_b_head       = bh_inc;
            new_b_cnt        = b_m1;
          end else begin
            new_f_cnt = f_m1;
          end
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          plan.was_empty = 1'b1;
        end else if (b_cnt == '0) begin
          plan.pop_rd = 1'b1;
          pop_addr    = a_flast;
          new_f_cnt   = f_m1;
        end else begin
          plan.pop_rd     = 1'b1;
          plan.pop_from_b = 1'b1;
          pop_addr        = a_blast;
          if (f_eq_b1) begin
            plan.move  = 1'b1;
            mv_rd_addr = a_flast;
            mv_wr_addr = bh_dec;
            new_b_head = bh_dec;
            new_f_cnt  = f_m1;
          end else begin
            new_b_cnt = b_m1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/front_middle_back_queue_top.sv
`timescale 1ns / 1ps
// An accepted item passes the read state and then the write state, where out_valid is high.
// Busy is high for the cycle in which the half memories are read, so no item is taken
// then; a new item is taken while the previous result shows.
// Each result is on the ports for one cycle only, since the receiver cannot stall.
// Synchronous active-low reset clears the heads, counts and sequencer; the stores
// are not cleared and need no clearing pass.

module front_middle_back_queue_top #(
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [fmbq_pkg::ACTION_W-1:0]    in_action,
  input  logic signed [fmbq_pkg::DATA_W-1:0] in_push_value,
  output logic                             out_valid,
  output logic signed [fmbq_pkg::DATA_W-1:0] out_pop_value,
  output logic                             out_was_empty,
  output logic                             out_push_dropped,
  output logic [fmbq_pkg::OUT_CNT_W-1:0]   out_item_count
);
  import fmbq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] f_cnt_r, f_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;
  logic [AW-1:0] f_head_r, f_head_nxt;
  logic [AW-1:0] b_head_r, b_head_nxt;

  fmbq_plan_t        plan_r;
  logic [AW-1:0]     pop_addr_r;
  logic [AW-1:0]     mv_rd_addr_r;
  logic [AW-1:0]     mv_wr_addr_r;
  logic [AW-1:0]     push_addr_r;
  logic [DATA_W-1:0] push_value_r;

  fmbq_plan_t    plan;
  logic [AW-1:0] pop_addr, mv_rd_addr, mv_wr_addr, push_addr;
  logic          accept;

  logic              f_rd_en, b_rd_en, f_wr_en, b_wr_en;
  logic [AW-1:0]     f_rd_addr, b_rd_addr, f_wr_addr, b_wr_addr;
  logic [DATA_W-1:0] f_wr_data, b_wr_data, f_rd_data, b_rd_data;
  logic [DATA_W-1:0] move_data;
  logic              in_read, in_write;

  fmbq_plan #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_plan (
    .action(in_action),
    .f_cnt(f_cnt_r),
    .f_head(f_head_r),
    .b_cnt(b_cnt_r),
    .b_head(b_head_r),
    .plan(plan),
    .pop_addr(pop_addr),
    .mv_rd_addr(mv_rd_addr),
    .mv_wr_addr(mv_wr_addr),
    .push_addr(push_addr),
    .new_f_cnt(f_cnt_nxt),
    .new_f_head(f_head_nxt),
    .new_b_cnt(b_cnt_nxt),
    .new_b_head(b_head_nxt)
  );

  assign busy   = (state_r == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = ST_IDLE;
    if (accept) begin
      state_nxt = ST_READ;
    end else if (state_r == ST_READ) begin
      state_nxt = ST_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      f_cnt_r  <= '0;
      b_cnt_r  <= '0;
      f_head_r <= '0;
      b_head_r <= '0;
      plan_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        f_cnt_r  <= f_cnt_nxt;
        b_cnt_r  <= b_cnt_nxt;
        f_head_r <= f_head_nxt;
        b_head_r <= b_head_nxt;
        plan_r   <= plan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_addr_r   <= pop_addr;
      mv_rd_addr_r <= mv_rd_addr;
      mv_wr_addr_r <= mv_wr_addr;
      push_addr_r  <= push_addr;
      push_value_r <= in_push_value;
    end
  end

  assign in_read  = (state_r == ST_READ);
  assign in_write = (state_r == ST_WRITE);

  always_comb begin
    f_rd_en   = 1'b0;
    b_rd_en   = 1'b0;
    f_rd_addr = mv_rd_addr_r;
    b_rd_addr = mv_rd_addr_r;
    if (in_read) begin
      if (plan_r.pop_rd && !plan_r.pop_from_b) begin
        f_rd_en   = 1'b1;
        f_rd_addr = pop_addr_r;
      end else if (plan_r.move && !plan_r.move_from_b) begin
        f_rd_en = 1'b1;
      end
      if (plan_r.pop_rd && plan_r.pop_from_b) begin
        b_rd_en   = 1'b1;
        b_rd_addr = pop_addr_r;
      end else if (plan_r.move && plan_r.move_from_b) begin
        b_rd_en = 1'b1;
      end
    end
  end

  assign move_data = plan_r.move_from_in ? push_value_r :
                     (plan_r.move_from_b ? b_rd_data : f_rd_data);

  always_comb begin
    f_wr_en   = 1'b0;
    b_wr_en   = 1'b0;
    f_wr_addr = mv_wr_addr_r;
    b_wr_addr = mv_wr_addr_r;
    f_wr_data = move_data;
    b_wr_data = move_data;
    if (in_write) begin
      if (plan_r.push_wr && !plan_r.push_to_b) begin
        f_wr_en   = 1'b1;
        f_wr_addr = push_addr_r;
        f_wr_data = push_value_r;
      end else if (plan_r.move && plan_r.move_from_b) begin
        f_wr_en = 1'b1;
      end
      if (plan_r.push_wr && plan_r.push_to_b) begin
        b_wr_en   = 1'b1;
        b_wr_addr = push_addr_r;
        b_wr_data = push_value_r;
      end else if (plan_r.move && !plan_r.move_from_b) begin
        b_wr_en = 1'b1;
      end
    end
  end

  fmbq_mem #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_front_mem (
    .clk(clk),
    .rd_en(f_rd_en),
    .rd_addr(f_rd_addr),
    .wr_en(f_wr_en),
    .wr_addr(f_wr_addr),
    .wr_data(f_wr_data),
    .rd_data(f_rd_data)
  );

  fmbq_mem #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_back_mem (
    .clk(clk),
    .rd_en(b_rd_en),
    .rd_addr(b_rd_addr),
    .wr_en(b_wr_en),
    .wr_addr(b_wr_addr),
    .wr_data(b_wr_data),
    .rd_data(b_rd_data)
  );

  logic [CW-1:0] total_cnt;

  assign total_cnt        = f_cnt_r + b_cnt_r;
  assign out_valid        = in_write;
  assign out_pop_value    = !plan_r.pop_rd ? EMPTY_VALUE :
                            (plan_r.pop_from_b ? b_rd_data : f_rd_data);
  assign out_was_empty    = plan_r.was_empty;
  assign out_push_dropped = plan_r.push_dropped;
  assign out_item_count   = OUT_CNT_W'(total_cnt);

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (f_cnt_r == b_cnt_r) || (f_cnt_r == b_cnt_r + CW'(1)))
    else $error("halves out of balance");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_cnt <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ))
    else $error("accepted item did not start its read cycle");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid)
    else $error("read cycle not followed by a result");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_empty && out_push_dropped))
    else $error("empty and dropped flags both set");

  a_write_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (f_wr_en || b_wr_en) |-> in_write && !f_rd_en && !b_rd_en)
    else $error("memory write outside the write cycle");

endmodule
